@@ hdl/stereo_correlation_tracker_unit_assert.svh @@
// Assertion macros shared by the tracker RTL.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef STEREO_CORRELATION_TRACKER_UNIT_ASSERT_SVH
`define STEREO_CORRELATION_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define SCT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/sct_pkg.sv @@
// Shared constants and types for the stereo correlation tracker.
// No dependencies.
package sct_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int ALPHA_BITS     = 16;
   localparam int ACC_BITS       = 56;
   localparam int WORD_BITS      = 64;
   localparam int MUL_BITS       = 32;
   localparam int PROD_BITS      = 2 * ACC_BITS;
   localparam int PEAK_BITS      = SAMPLE_BITS + 1;
   localparam int OUT_PEAK_BITS  = 24;
   localparam int CORR_FRAC      = 15;
   localparam int CORR_BITS      = CORR_FRAC + 1;
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int ROOT_STEPS     = ACC_BITS;
   localparam int STEP_CNT_BITS  = $clog2(ROOT_STEPS + 1);
   localparam int SUB_BITS       = ACC_BITS + 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SMOOTHING = 0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FLOOR     = 1;

   localparam logic [CFG_BITS-1:0] SMOOTHING_RESET = 16'd65531;
   localparam logic [CFG_BITS-1:0] FLOOR_RESET     = 16'd70;

   localparam logic [1:0] SHIFT_NONE = 2'd0;
   localparam logic [1:0] SHIFT_ONE  = 2'd1;
   localparam logic [1:0] SHIFT_TWO  = 2'd2;

   typedef struct packed {
      logic       en;
      logic       add;
      logic [1:0] shift;
   } mac_cmd_type;

   typedef struct packed {
      logic go_root;
      logic go_div;
   } rd_cmd_type;

endpackage

@@ hdl/sct_if.sv @@
// Channel interfaces for the tracker: sample requests, results, register writes.
// Depends on sct_pkg.
interface sct_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sct_pkg::SAMPLE_BITS-1:0] left_sample;
   logic signed [sct_pkg::SAMPLE_BITS-1:0] right_sample;
   logic                                  begin_block;
   modport source (output valid, left_sample, right_sample, begin_block, input ready);
   modport sink (input valid, left_sample, right_sample, begin_block, output ready);
endinterface

interface sct_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sct_pkg::CORR_BITS-1:0] correlation_value;
   logic                                 correlation_valid;
   logic [sct_pkg::OUT_PEAK_BITS-1:0]    peak_difference;
   modport source (output valid, correlation_value, correlation_valid, peak_difference,
                   input ready);
   modport sink (input valid, correlation_value, correlation_valid, peak_difference,
                 output ready);
endinterface

interface sct_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sct_pkg::CSR_INDEX_BITS-1:0] index;
   logic [sct_pkg::CFG_BITS-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/sct_mac.sv @@
// Shared 32x32 multiplier with a wide shifting accumulator.
// Depends on sct_pkg.
module sct_mac (
   input  logic                           clock,
   input  sct_pkg::mac_cmd_type           cmd,
   input  logic [sct_pkg::MUL_BITS-1:0]   op_a,
   input  logic [sct_pkg::MUL_BITS-1:0]   op_b,
   output logic [sct_pkg::PROD_BITS-1:0]  acc
);
   logic [2*sct_pkg::MUL_BITS-1:0] product;
   logic [sct_pkg::PROD_BITS-1:0]  shifted;
   logic [sct_pkg::PROD_BITS-1:0]  acc_ff;
   logic [sct_pkg::PROD_BITS-1:0]  acc_in;

   assign product = op_a * op_b;

   always_comb begin
      unique case (cmd.shift)
         sct_pkg::SHIFT_NONE: shifted = sct_pkg::PROD_BITS'(product);
         sct_pkg::SHIFT_ONE:  shifted = sct_pkg::PROD_BITS'(product) << sct_pkg::MUL_BITS;
         sct_pkg::SHIFT_TWO:  shifted = sct_pkg::PROD_BITS'(product) << (2 * sct_pkg::MUL_BITS);
         default:             shifted = '0;
      endcase
      acc_in = cmd.add ? acc_ff + shifted : shifted;
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule

@@ hdl/sct_rootdiv.sv @@
// Iterative integer square root and fraction divide on one compare-subtract unit.
// Depends on sct_pkg.
module sct_rootdiv (
   input  logic                           clock,
   input  logic                           reset,
   input  sct_pkg::rd_cmd_type            cmd,
   input  logic [sct_pkg::PROD_BITS-1:0]  radicand,
   input  logic [sct_pkg::ACC_BITS-1:0]   dividend,
   output logic [sct_pkg::ACC_BITS-1:0]   root,
   output logic [sct_pkg::CORR_FRAC-1:0]  quot,
   output logic                           busy
);
   localparam int SW = sct_pkg::SUB_BITS;
   localparam int AW = sct_pkg::ACC_BITS;
   localparam int NW = sct_pkg::PROD_BITS;

   logic [NW-1:0]                      n_ff, n_in;
   logic [SW-1:0]                      rem_ff, rem_in;
   logic [AW-1:0]                      root_ff, root_in;
   logic [sct_pkg::CORR_FRAC-1:0]      quot_ff, quot_in;
   logic [sct_pkg::STEP_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                               busy_ff, busy_in;
   logic                               div_mode_ff, div_mode_in;
   logic [SW-1:0]                      sub_a, sub_b;
   logic [SW:0]                        diff;
   logic                               ge;

   // one shared subtractor; operands picked by mode
   always_comb begin
      if (div_mode_ff) begin
         sub_a = {rem_ff[SW-2:0], 1'b0};
         sub_b = SW'(root_ff);
      end else begin
         sub_a = {rem_ff[SW-3:0], n_ff[NW-1 -: 2]};
         sub_b = SW'({root_ff, 2'b01});
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = !diff[SW];
   end

   always_comb begin
      n_in        = n_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      quot_in     = quot_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      div_mode_in = div_mode_ff;
      priority if (cmd.go_root) begin
         n_in        = radicand;
         rem_in      = '0;
         root_in     = '0;
         cnt_in      = sct_pkg::STEP_CNT_BITS'(sct_pkg::ROOT_STEPS);
         busy_in     = 1'b1;
         div_mode_in = 1'b0;
      end else if (cmd.go_div) begin
         rem_in      = SW'(dividend);
         quot_in     = '0;
         cnt_in      = sct_pkg::STEP_CNT_BITS'(sct_pkg::CORR_FRAC);
         busy_in     = 1'b1;
         div_mode_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[SW-1:0] : sub_a;
         if (div_mode_ff) begin
            quot_in = {quot_ff[sct_pkg::CORR_FRAC-2:0], ge};
         end else begin
            root_in = {root_ff[AW-2:0], ge};
            n_in    = n_ff << 2;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == sct_pkg::STEP_CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
         div_mode_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         div_mode_ff <= div_mode_in;
      end
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      quot_ff <= quot_in;
   end

   assign root = root_ff;
   assign quot = quot_ff;
   assign busy = busy_ff;
endmodule

@@ hdl/stereo_correlation_tracker_unit.sv @@
// Top level of the stereo correlation tracker: sequencer, accumulators, output register.
// Depends on sct_pkg, sct_if, sct_mac, sct_rootdiv and the assertion header.
//
// One sample pair is taken at a time; req_channel.ready is high only while the
// sequencer is idle. After the input transfer the sequencer runs these steps in
// order: the multiply steps that update the three smoothed accumulators on the
// shared 32x32 multiplier, the four partial products that form the energy product,
// a launch step, 56 square root steps and a finish step on one compare-subtract
// unit, a check step and the load into the output register. Unless the correlation
// is clamped or unavailable, 15 divide steps and a finish step run before the load.
// Ready returns in the cycle after the load. The finished result sits in an
// output register, so the next pair is taken while it waits; a later result
// holds in the load cycle until that register is free.
`include "stereo_correlation_tracker_unit_assert.svh"

module stereo_correlation_tracker_unit (
   input logic       clock,
   input logic       reset,
   sct_req_if.sink   req_channel,
   sct_rsp_if.source rsp_channel,
   sct_csr_if.sink   csr_channel
);
   localparam int SB = sct_pkg::SAMPLE_BITS;
   localparam int AW = sct_pkg::ACC_BITS;
   localparam int WW = sct_pkg::WORD_BITS;
   localparam int MB = sct_pkg::MUL_BITS;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MAC     = 3'd1;
   localparam logic [2:0] ST_PROD    = 3'd2;
   localparam logic [2:0] ST_ROOT_GO = 3'd3;
   localparam logic [2:0] ST_ROOT    = 3'd4;
   localparam logic [2:0] ST_CHECK   = 3'd5;
   localparam logic [2:0] ST_DIV     = 3'd6;
   localparam logic [2:0] ST_DONE    = 3'd7;

   logic [2:0]                       state_ff, state_in;
   logic [1:0]                       k_ff, k_in;
   logic [2:0]                       sub_ff, sub_in;
   logic [sct_pkg::CFG_BITS-1:0]     smooth_ff, floor_ff;
   logic signed [SB-1:0]             l_ff, r_ff;
   logic [AW-1:0]                    le_ff, re_ff, cross_ff;
   logic [AW-1:0]                    le_in, re_in, cross_in;
   logic [sct_pkg::PEAK_BITS-1:0]    peak_ff, peak_in;
   logic [WW-1:0]                    p_ff, p_in;
   logic                             avail_ff, clamp_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [sct_pkg::CORR_BITS-1:0] rsp_value_ff;
   logic                             rsp_flag_ff;
   logic [sct_pkg::OUT_PEAK_BITS-1:0] rsp_peak_ff;

   sct_pkg::mac_cmd_type             mac_cmd;
   logic [MB-1:0]                    mac_a, mac_b;
   logic [sct_pkg::PROD_BITS-1:0]    mac_acc;
   sct_pkg::rd_cmd_type              rd_cmd;
   logic [AW-1:0]                    root;
   logic [sct_pkg::CORR_FRAC-1:0]    quot;
   logic                             rd_busy;

   logic                             req_xfer, load_out;
   logic [SB-1:0]                    l_mag, r_mag, x_mag, y_mag;
   logic                             neg_k;
   logic [WW-1:0]                    acc64;
   logic [WW-1:0]                    sum;
   logic signed [WW-1:0]             sum_s;
   logic [MB-1:0]                    alpha, blend;
   logic [AW-1:0]                    mag;
   logic                             cross_neg;
   logic                             avail_now, clamp_now;
   logic signed [SB:0]               diff;
   logic [SB:0]                      diff_abs;
   logic [sct_pkg::PEAK_BITS-1:0]    peak_base;
   logic [sct_pkg::CORR_BITS-1:0]    q_mag;
   logic signed [sct_pkg::CORR_BITS-1:0] value_out;

   sct_mac u_mac (
      .clock (clock),
      .cmd   (mac_cmd),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   sct_rootdiv u_rootdiv (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rd_cmd),
      .radicand (mac_acc),
      .dividend (mag),
      .root     (root),
      .quot     (quot),
      .busy     (rd_busy)
   );

   assign req_channel.ready = (state_ff == ST_IDLE);
   assign req_xfer          = req_channel.valid && req_channel.ready;
   assign csr_channel.ready = 1'b1;

   assign alpha = MB'(smooth_ff[sct_pkg::ALPHA_BITS-1:0]);
   assign blend = MB'((sct_pkg::ALPHA_BITS+1)'(1) << sct_pkg::ALPHA_BITS)
                  - MB'(smooth_ff[sct_pkg::ALPHA_BITS-1:0]);

   assign l_mag = l_ff[SB-1] ? SB'(-l_ff) : SB'(l_ff);
   assign r_mag = r_ff[SB-1] ? SB'(-r_ff) : SB'(r_ff);

   assign cross_neg = cross_ff[AW-1];
   assign mag       = cross_neg ? AW'(-cross_ff) : cross_ff;
   assign avail_now = root > AW'(floor_ff);
   assign clamp_now = mag >= root;

   assign sum   = mac_acc[WW-1:0];
   assign sum_s = mac_acc[WW-1:0];

   // peak update at the input transfer
   always_comb begin
      diff      = (SB+1)'(req_channel.left_sample) - (SB+1)'(req_channel.right_sample);
      diff_abs  = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);
      peak_base = req_channel.begin_block ? '0 : peak_ff;
      peak_in   = peak_ff;
      if (req_xfer) begin
         peak_in = (sct_pkg::PEAK_BITS'(diff_abs) > peak_base) ?
                   sct_pkg::PEAK_BITS'(diff_abs) : peak_base;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      unique case (k_ff)
         2'd0: begin
            x_mag = l_mag;
            y_mag = l_mag;
            neg_k = 1'b0;
            acc64 = WW'(le_ff);
         end
         2'd1: begin
            x_mag = r_mag;
            y_mag = r_mag;
            neg_k = 1'b0;
            acc64 = WW'(re_ff);
         end
         default: begin
            x_mag = l_mag;
            y_mag = r_mag;
            neg_k = l_ff[SB-1] ^ r_ff[SB-1];
            acc64 = {{(WW-AW){cross_ff[AW-1]}}, cross_ff};
         end
      endcase

      mac_cmd = '0;
      mac_a   = '0;
      mac_b   = '0;
      if (state_ff == ST_MAC) begin
         unique case (sub_ff)
            3'd0: begin
               mac_cmd = '{en: 1'b1, add: 1'b0, shift: sct_pkg::SHIFT_NONE};
               mac_a   = MB'(x_mag);
               mac_b   = MB'(y_mag);
            end
            3'd1: begin
               mac_cmd = '{en: 1'b1, add: 1'b0, shift: sct_pkg::SHIFT_NONE};
               mac_a   = alpha;
               mac_b   = acc64[MB-1:0];
            end
            3'd2: begin
               mac_cmd = '{en: 1'b1, add: 1'b1, shift: sct_pkg::SHIFT_ONE};
               mac_a   = alpha;
               mac_b   = acc64[WW-1:MB];
            end
            3'd3: begin
               mac_cmd = '{en: 1'b1, add: 1'b1, shift: sct_pkg::SHIFT_NONE};
               mac_a   = blend;
               mac_b   = p_ff[MB-1:0];
            end
            3'd4: begin
               mac_cmd = '{en: 1'b1, add: 1'b1, shift: sct_pkg::SHIFT_ONE};
               mac_a   = blend;
               mac_b   = p_ff[WW-1:MB];
            end
            default: begin
               mac_cmd = '0;
            end
         endcase
      end else if (state_ff == ST_PROD) begin
         unique case (sub_ff[1:0])
            2'd0: begin
               mac_cmd = '{en: 1'b1, add: 1'b0, shift: sct_pkg::SHIFT_NONE};
               mac_a   = le_ff[MB-1:0];
               mac_b   = re_ff[MB-1:0];
            end
            2'd1: begin
               mac_cmd = '{en: 1'b1, add: 1'b1, shift: sct_pkg::SHIFT_ONE};
               mac_a   = le_ff[MB-1:0];
               mac_b   = MB'(re_ff[AW-1:MB]);
            end
            2'd2: begin
               mac_cmd = '{en: 1'b1, add: 1'b1, shift: sct_pkg::SHIFT_ONE};
               mac_a   = MB'(le_ff[AW-1:MB]);
               mac_b   = re_ff[MB-1:0];
            end
            default: begin
               mac_cmd = '{en: 1'b1, add: 1'b1, shift: sct_pkg::SHIFT_TWO};
               mac_a   = MB'(le_ff[AW-1:MB]);
               mac_b   = MB'(re_ff[AW-1:MB]);
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      sub_in   = sub_ff;
      rd_cmd   = '0;
      load_out = 1'b0;
      le_in    = le_ff;
      re_in    = re_ff;
      cross_in = cross_ff;
      p_in     = p_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_MAC;
               k_in     = '0;
               sub_in   = '0;
            end
         end
         ST_MAC: begin
            if (sub_ff == 3'd1) begin
               // latch the signed sample product before the accumulator is reused
               p_in = neg_k ? WW'(-sum) : sum;
            end
            if (sub_ff == 3'd5) begin
               unique case (k_ff)
                  2'd0:    le_in    = AW'(sum >> sct_pkg::ALPHA_BITS);
                  2'd1:    re_in    = AW'(sum >> sct_pkg::ALPHA_BITS);
                  default: cross_in = AW'(sum_s >>> sct_pkg::ALPHA_BITS);
               endcase
               sub_in = '0;
               if (k_ff == 2'd2) begin
                  state_in = ST_PROD;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
         ST_PROD: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 3'd3) begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            rd_cmd.go_root = 1'b1;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            if (!rd_busy) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (avail_now && !clamp_now) begin
               rd_cmd.go_div = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (!rd_busy) begin
               state_in = ST_DONE;
            end
         end
         default: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_channel.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      if (clamp_ff) begin
         q_mag = cross_neg ? sct_pkg::CORR_BITS'(1) << sct_pkg::CORR_FRAC
                           : (sct_pkg::CORR_BITS'(1) << sct_pkg::CORR_FRAC) - 1'b1;
      end else begin
         q_mag = sct_pkg::CORR_BITS'(quot);
      end
      value_out = avail_ff ? (cross_neg ? -$signed(q_mag) : $signed(q_mag)) : '0;
      rsp_valid_in = load_out ? 1'b1 : (rsp_channel.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         sub_ff       <= '0;
         smooth_ff    <= sct_pkg::SMOOTHING_RESET;
         floor_ff     <= sct_pkg::FLOOR_RESET;
         le_ff        <= '0;
         re_ff        <= '0;
         cross_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         sub_ff       <= sub_in;
         le_ff        <= le_in;
         re_ff        <= re_in;
         cross_ff     <= cross_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_channel.valid && csr_channel.ready) begin
            if (csr_channel.index == sct_pkg::REG_SMOOTHING) begin
               smooth_ff <= csr_channel.data;
            end else if (csr_channel.index == sct_pkg::REG_FLOOR) begin
               floor_ff <= csr_channel.data;
            end
         end
      end
      p_ff <= p_in;
      if (req_xfer) begin
         l_ff <= req_channel.left_sample;
         r_ff <= req_channel.right_sample;
      end
      if (state_ff == ST_CHECK) begin
         avail_ff <= avail_now;
         clamp_ff <= clamp_now;
      end
      if (load_out) begin
         rsp_value_ff <= value_out;
         rsp_flag_ff  <= avail_ff;
         rsp_peak_ff  <= (peak_ff > sct_pkg::PEAK_BITS'({sct_pkg::OUT_PEAK_BITS{1'b1}})) ?
                         {sct_pkg::OUT_PEAK_BITS{1'b1}} :
                         peak_ff[sct_pkg::OUT_PEAK_BITS-1:0];
      end
   end

   assign rsp_channel.valid             = rsp_valid_ff;
   assign rsp_channel.correlation_value = rsp_value_ff;
   assign rsp_channel.correlation_valid = rsp_flag_ff;
   assign rsp_channel.peak_difference   = rsp_peak_ff;

   `SCT_ASSERT_NEXT(a_transfer_starts_mac, req_xfer, state_ff == ST_MAC)
   `SCT_ASSERT_NOW(a_div_only_when_needed, rd_cmd.go_div, avail_now && (mag < root))
   `SCT_ASSERT_NOW(a_no_cmd_while_busy, rd_cmd.go_root || rd_cmd.go_div, !rd_busy)
   `SCT_ASSERT_NOW(a_zero_when_unavailable, rsp_valid_ff && !rsp_flag_ff, rsp_value_ff == '0)

endmodule

@@ tb/sv/stereo_correlation_tracker_unit_tb_if.sv @@
// Testbench-side note: the channel interfaces come from the RTL file hdl/sct_if.sv.
// This file holds the small helper package used by the testbench; depends on sct_pkg.
package sct_tb_pkg;
   import sct_pkg::*;

   typedef struct {
      logic signed [CORR_BITS-1:0] corr;
      logic                        avail;
      logic [OUT_PEAK_BITS-1:0]    peak;
   } meter_reading_type;
endpackage

@@ tb/sv/stereo_correlation_tracker_unit_tb.sv @@
// Testbench for stereo_correlation_tracker_unit: drives sample pairs and register writes,
// predicts each meter reading with its own integer model and checks every result.
// Depends on sct_pkg, the RTL interfaces and sct_tb_pkg.
module stereo_correlation_tracker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sct_pkg::*;
   import sct_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 150;

   logic clock = 0;
   logic reset = 1;

   sct_req_if req_channel ();
   sct_rsp_if rsp_channel ();
   sct_csr_if csr_channel ();

   stereo_correlation_tracker_unit u_top (
      .clock(clock), .reset(reset),
      .req_channel(req_channel), .rsp_channel(rsp_channel), .csr_channel(csr_channel)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // meter state
   logic [CFG_BITS-1:0]      alpha_reg;
   logic [CFG_BITS-1:0]      floor_reg;
   logic [ACC_BITS-1:0]      left_energy;
   logic [ACC_BITS-1:0]      right_energy;
   logic signed [ACC_BITS-1:0] cross_energy;
   logic [PEAK_BITS-1:0]     peak_hold;

   meter_reading_type expected_readings[$];
   int  mismatch_count = 0;
   int  reading_count  = 0;
   int  idle_cycles    = 0;
   int  valid_count    = 0;
   int  clamp_count    = 0;
   bit  rsp_stall_mode = 0;

   function automatic logic [ACC_BITS-1:0] int_sqrt(logic [2*ACC_BITS-1:0] n);
      logic [ACC_BITS-1:0]   r;
      logic [ACC_BITS-1:0]   t;
      r = '0;
      for (int b = ACC_BITS - 1; b >= 0; b--) begin
         t = r | ({{(ACC_BITS-1){1'b0}}, 1'b1} << b);
         if (({{ACC_BITS{1'b0}}, t} * {{ACC_BITS{1'b0}}, t}) <= n) r = t;
      end
      return r;
   endfunction

   task automatic predict_reading(logic signed [SAMPLE_BITS-1:0] l,
                                  logic signed [SAMPLE_BITS-1:0] r, logic blk);
      logic signed [127:0] lw, rw, a, bl, cr;
      logic [127:0]        diff;
      logic [ACC_BITS-1:0] root, mag;
      logic [15:0]         q;
      logic [ACC_BITS:0]   rem;
      logic                neg;
      meter_reading_type   m;
      lw = l;
      rw = r;
      a  = {112'd0, alpha_reg};
      bl = 128'sd65536 - a;
      if (blk) peak_hold = '0;
      left_energy  = ACC_BITS'((a * {72'd0, left_energy} + bl * (lw * lw)) >>> ALPHA_BITS);
      right_energy = ACC_BITS'((a * {72'd0, right_energy} + bl * (rw * rw)) >>> ALPHA_BITS);
      cr = cross_energy;
      cross_energy = ACC_BITS'((a * cr + bl * (lw * rw)) >>> ALPHA_BITS);
      diff = (lw >= rw) ? 128'(lw - rw) : 128'(rw - lw);
      if (diff > peak_hold) peak_hold = diff[PEAK_BITS-1:0];
      root = int_sqrt({{ACC_BITS{1'b0}}, left_energy} * {{ACC_BITS{1'b0}}, right_energy});
      neg = cross_energy < 0;
      mag = neg ? -cross_energy : cross_energy;
      m.peak = peak_hold[PEAK_BITS-1] ? '1 : peak_hold[OUT_PEAK_BITS-1:0];
      if (root <= {40'd0, floor_reg}) begin
         m.corr  = '0;
         m.avail = 0;
      end else begin
         m.avail = 1;
         valid_count++;
         if (mag >= root) begin
            q = neg ? 16'h8000 : 16'h7fff;
            clamp_count++;
         end else begin
            q = '0;
            rem = {1'b0, mag};
            for (int i = 0; i < CORR_FRAC; i++) begin
               rem = rem << 1;
               q = q << 1;
               if (rem >= {1'b0, root}) begin
                  rem = rem - {1'b0, root};
                  q[0] = 1;
               end
            end
         end
         m.corr = neg ? -q : q;
      end
      expected_readings.push_back(m);
   endtask

   // result checker with its own stall pattern
   always @(posedge clock) begin
      meter_reading_type exp_r;
      if (reset) begin
         rsp_channel.ready <= 0;
      end else begin
         if (rsp_channel.valid && rsp_channel.ready) begin
            reading_count++;
            if (expected_readings.size() == 0) begin
               $error("unexpected result transfer");
               mismatch_count++;
            end else begin
               exp_r = expected_readings.pop_front();
               if (rsp_channel.correlation_value !== exp_r.corr) begin
                  $error("correlation_value exp %0d got %0d", exp_r.corr,
                         rsp_channel.correlation_value);
                  mismatch_count++;
               end
               if (rsp_channel.correlation_valid !== exp_r.avail) begin
                  $error("correlation_valid exp %0d got %0d", exp_r.avail,
                         rsp_channel.correlation_valid);
                  mismatch_count++;
               end
               if (rsp_channel.peak_difference !== exp_r.peak) begin
                  $error("peak_difference exp %0d got %0d", exp_r.peak,
                         rsp_channel.peak_difference);
                  mismatch_count++;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_stall_mode <= ~rsp_stall_mode;
         rsp_channel.ready <= rsp_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_channel.valid && req_channel.ready) ||
          (rsp_channel.valid && rsp_channel.ready) ||
          (csr_channel.valid && csr_channel.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   int burst_left = 0;

   task automatic send_pair(logic signed [SAMPLE_BITS-1:0] l,
                            logic signed [SAMPLE_BITS-1:0] r, logic blk);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150)) @(posedge clock);
      end
      burst_left--;
      req_channel.valid        <= 1;
      req_channel.left_sample  <= l;
      req_channel.right_sample <= r;
      req_channel.begin_block  <= blk;
      do @(posedge clock); while (!req_channel.ready);
      predict_reading(l, r, blk);
      req_channel.valid <= 0;
      // let the drop of valid take effect before the next pair is driven
      @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      wait (expected_readings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_channel.valid <= 1;
      csr_channel.index <= idx;
      csr_channel.data  <= val;
      do @(posedge clock); while (!csr_channel.ready);
      csr_channel.valid <= 0;
      if (idx == REG_SMOOTHING) alpha_reg = val;
      else if (idx == REG_FLOOR) floor_reg = val;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         1: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic test_directed_extremes();
      write_register(REG_SMOOTHING, 16'd0);
      write_register(REG_FLOOR, 16'd0);
      send_pair(24'sh7fffff, 24'sh7fffff, 1);
      send_pair(24'sh7fffff, 24'sh800000, 0);
      send_pair(24'sh800000, 24'sh800000, 0);
      send_pair(24'sh800000, 24'sh7fffff, 1);
      send_pair(24'sh000000, 24'sh000000, 0);
      send_pair(24'sh000001, 24'sh000000, 1);
      send_pair(24'sh400000, -24'sh200000, 0);
      send_pair(24'sh123456, 24'sh0fedcb, 0);
      write_register(REG_FLOOR, 16'hffff);
      send_pair(24'sh7fffff, 24'sh7fffff, 1);
      send_pair(24'sh000010, 24'sh000020, 0);
      write_register(REG_SMOOTHING, 16'hffff);
      write_register(REG_FLOOR, FLOOR_RESET);
      send_pair(24'sh7fffff, 24'sh7fffff, 0);
      send_pair(24'sh800000, 24'sh7fffff, 0);
      send_pair(24'sh000003, 24'sh000005, 0);
      // index beyond the register list is ignored
      write_register(4'hf, 16'h1234);
      send_pair(24'sh010000, 24'sh008000, 1);
   endtask

   task automatic test_random_phase(logic [CFG_BITS-1:0] alpha, logic [CFG_BITS-1:0] flr,
                                    int count);
      logic signed [SAMPLE_BITS-1:0] l, r;
      write_register(REG_SMOOTHING, alpha);
      write_register(REG_FLOOR, flr);
      for (int i = 0; i < count; i++) begin
         l = rand_sample();
         case ($urandom_range(0, 3))
            0: r = l;
            1: r = -l;
            default: r = rand_sample();
         endcase
         send_pair(l, r, $urandom_range(0, 15) == 0);
      end
   endtask

   initial begin
      req_channel.valid = 0;
      req_channel.left_sample = '0;
      req_channel.right_sample = '0;
      req_channel.begin_block = 0;
      csr_channel.valid = 0;
      csr_channel.index = '0;
      csr_channel.data = '0;
      alpha_reg = SMOOTHING_RESET;
      floor_reg = FLOOR_RESET;
      left_energy = '0;
      right_energy = '0;
      cross_energy = '0;
      peak_hold = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // reset settings first
      for (int i = 0; i < 40; i++) send_pair(rand_sample(), rand_sample(), i == 0);
      test_directed_extremes();
      test_random_phase(16'd0, 16'd0, 150);
      test_random_phase(SMOOTHING_RESET, FLOOR_RESET, 200);
      test_random_phase(16'hffff, 16'hffff, 100);
      test_random_phase(16'h8000, 16'd70, 150);
      test_random_phase(16'($urandom), 16'($urandom), 160);
      wait (expected_readings.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d readings: %0d available, %0d clamped at full scale.",
               reading_count, valid_count, clamp_count);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
